// ----- sv/b64dv_pkg.sv -----
// ----------------------------------------------------------------------------
// b64dv_pkg: shared definitions for the validating base64 decoder
// Status codes, the pad character and the alphabet lookup used by the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64dv_pkg;

  // Message status codes, reported with the last character.
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_BAD_CHAR   = 3'd1;
  localparam logic [2:0] STAT_AFTER_PAD  = 3'd2;
  localparam logic [2:0] STAT_MANY_PADS  = 3'd3;
  localparam logic [2:0] STAT_BAD_LENGTH = 3'd4;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
  localparam logic [1:0] PAD_MAX  = 2'd3;

  // Sextet lookup result: a flag for characters outside both alphabets.
  typedef struct packed {
    logic       bad;
    logic [5:0] value;
  } sextet_t;

  // Maps a character of the standard or URL-safe alphabet to its 6-bit value.
  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t res;
    res.bad   = 1'b0;
    res.value = 6'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      res.value = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      res.value = 6'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      res.value = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B || ch == 8'h2D) begin
      res.value = 6'd62;
    end else if (ch == 8'h2F || ch == 8'h5F) begin
      res.value = 6'd63;
    end else begin
      res.bad = 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- sv/base64_decoder_validating.sv -----
// ----------------------------------------------------------------------------
// base64_decoder_validating: streaming base64 decoder with message status
// Decodes one character per request, emits each byte as it completes and
// reports a status with the character marked last.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_stall   | code_char, msg_last
//  output   | out_valid / out_stall | data_byte, byte_valid, msg_end, status
//
// One character is taken every cycle while in_stall is low; an accepted request passes
// from the input register to the result register, which drives the outputs.
// Rst is synchronous and active high; it clears the decode state and empties
// both registers.
// A stalled result holds the input register only when the waiting character
// itself produces a result; characters that produce nothing still drain.
// Characters after the last one start a fresh message with cleared state.
//
`default_nettype none

module base64_decoder_validating (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] code_char,
  input  wire logic       msg_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      data_byte,
  output logic            byte_valid,
  output logic            msg_end,
  output logic [2:0]      status
);

  // Input register.
  logic       in_held;
  logic [7:0] held_char;
  logic       held_last;

  // Decode state.
  logic [1:0] sextet_phase;
  logic [5:0] held_bits;
  logic       pad_seen;
  logic [1:0] pad_total;
  logic [2:0] first_error;

  logic [1:0] sextet_phase_next;
  logic [5:0] held_bits_next;
  logic       pad_seen_next;
  logic [1:0] pad_total_next;
  logic [2:0] first_error_next;

  b64dv_pkg::sextet_t sx;
  logic       have_byte;
  logic [7:0] byte_next;
  logic [2:0] status_next;
  logic       produces;
  logic       out_free;
  logic       advance;

  // Decode the held character against the current state.
  always_comb begin
    sx                = b64dv_pkg::sextet_of(held_char);
    sextet_phase_next = sextet_phase;
    held_bits_next    = held_bits;
    pad_seen_next     = pad_seen;
    pad_total_next    = pad_total;
    first_error_next  = first_error;
    have_byte         = 1'b0;
    byte_next         = 8'd0;
    if (held_char == b64dv_pkg::PAD_CHAR) begin
      pad_seen_next = 1'b1;
      if (pad_total != b64dv_pkg::PAD_MAX) begin
        pad_total_next = pad_total + 2'd1;
      end
    end else if (pad_seen) begin
      if (first_error == b64dv_pkg::STAT_OK) begin
        first_error_next = b64dv_pkg::STAT_AFTER_PAD;
      end
    end else if (sx.bad) begin
      if (first_error == b64dv_pkg::STAT_OK) begin
        first_error_next = b64dv_pkg::STAT_BAD_CHAR;
      end
    end else begin
      case (sextet_phase)
        2'd0: begin
          held_bits_next = sx.value;
        end
        2'd1: begin
          byte_next      = {held_bits, sx.value[5:4]};
          held_bits_next = {2'b00, sx.value[3:0]};
          have_byte      = 1'b1;
        end
        2'd2: begin
          byte_next      = {held_bits[3:0], sx.value[5:2]};
          held_bits_next = {4'b0000, sx.value[1:0]};
          have_byte      = 1'b1;
        end
        default: begin
          byte_next      = {held_bits[1:0], sx.value};
          held_bits_next = 6'd0;
          have_byte      = 1'b1;
        end
      endcase
      sextet_phase_next = sextet_phase + 2'd1;
    end

    // Status for the last character, first error taking priority.
    if (!held_last) begin
      status_next = b64dv_pkg::STAT_OK;
    end else if (first_error_next != b64dv_pkg::STAT_OK) begin
      status_next = first_error_next;
    end else if (pad_total_next == b64dv_pkg::PAD_MAX) begin
      status_next = b64dv_pkg::STAT_MANY_PADS;
    end else if (sextet_phase_next == 2'd1) begin
      status_next = b64dv_pkg::STAT_BAD_LENGTH;
    end else begin
      status_next = b64dv_pkg::STAT_OK;
    end
  end

  // Flow control: a character moves on unless its result has nowhere to go.
  assign produces = have_byte || held_last;
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_held && (out_free || !produces);
  assign in_stall = in_held && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (!in_stall) begin
      in_held <= in_valid;
    end
    if (!in_stall && in_valid) begin
      held_char <= code_char;
      held_last <= msg_last;
    end
  end

  // Decode state, cleared after the last character of a message.
  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_phase <= 2'd0;
      held_bits    <= 6'd0;
      pad_seen     <= 1'b0;
      pad_total    <= 2'd0;
      first_error  <= b64dv_pkg::STAT_OK;
    end else if (advance) begin
      if (held_last) begin
        sextet_phase <= 2'd0;
        held_bits    <= 6'd0;
        pad_seen     <= 1'b0;
        pad_total    <= 2'd0;
        first_error  <= b64dv_pkg::STAT_OK;
      end else begin
        sextet_phase <= sextet_phase_next;
        held_bits    <= held_bits_next;
        pad_seen     <= pad_seen_next;
        pad_total    <= pad_total_next;
        first_error  <= first_error_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produces) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && produces) begin
      data_byte  <= byte_next;
      byte_valid <= have_byte;
      msg_end    <= held_last;
      status     <= status_next;
    end
  end

  // The last character leaves a clean state for the next message.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && held_last |=> sextet_phase == 2'd0 && pad_total == 2'd0 &&
                             first_error == b64dv_pkg::STAT_OK)
    else $error("decode state not cleared after last character");

  // Leftover bits never exceed what the phase allows.
  a_held_width: assert property (@(posedge clk) disable iff (rst)
    (sextet_phase != 2'd0 || held_bits == 6'd0) &&
    (sextet_phase != 2'd2 || held_bits[5:4] == 2'b00) &&
    (sextet_phase != 2'd3 || held_bits[5:2] == 4'b0000))
    else $error("held bits wider than the sextet phase allows");

  // Pad flag and pad count agree.
  a_pad_agree: assert property (@(posedge clk) disable iff (rst)
    pad_seen == (pad_total != 2'd0))
    else $error("pad flag and pad count disagree");

  // A result carries a byte, the end of a message, or both.
  a_result_content: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_valid || msg_end)
    else $error("empty result presented");

  // Status is nonzero only at the end of a message.
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !msg_end |-> status == b64dv_pkg::STAT_OK)
    else $error("status set on a mid-message result");

endmodule

`default_nettype wire
